[rtl/core/cds_pkg.sv]
// Shared types, constants and small table functions for the calendar date stepper.
`default_nettype none

package cds_pkg;

  // Top-level parameter defaults
  localparam int unsigned YEAR_MAX_DEF  = 9999;
  localparam int unsigned COUNT_MAX_DEF = 255;

  // Field widths
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int WDAY_W  = 3;
  localparam int CNT_W   = 8;
  localparam int ACT_W   = 2;
  localparam int JDN_W   = 23;
  localparam int ACC_W   = 24;
  localparam int M400_W  = 9;
  localparam int QY_W    = 8;
  localparam int K2_W    = 9;

  // Shared multiplier operand widths
  localparam int MUL_AW = 24;
  localparam int MUL_BW = 24;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FWD  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_BACK = 2'd2;

  // Calendar constants
  localparam logic [MONTH_W-1:0] MONTHS   = 4'd12;
  localparam logic [MONTH_W-1:0] MARCH    = 4'd3;
  localparam logic [MONTH_W-1:0] MM_SHIFT = 4'd9;
  localparam logic [WDAY_W-1:0]  WD_LAST  = 3'd6;
  localparam int unsigned CENTURY   = 100;
  localparam int unsigned QUAD_CENT = 400;

  // Julian day number constants
  localparam int unsigned JDN_MUL    = 1461;
  localparam int unsigned JDN_YOFS   = 4712;
  localparam int unsigned JDN_DOFS   = 59;
  localparam int unsigned GREG_START = 2299160;
  localparam int unsigned GREG_CENT  = 49;
  localparam int unsigned GREG_OFS   = 38;

  // Reciprocals: floor(x/100) = (x*RCP100) >> RCP100_SH for x < 2^14,
  // floor(x/7) = (x*RCP7) >> RCP7_SH for x < 2^23
  localparam int unsigned RCP100    = 5243;
  localparam int unsigned RCP100_SH = 19;
  localparam int unsigned RCP7      = 9586981;
  localparam int unsigned RCP7_SH   = 26;

  // Reset date: 0001-01-01, a Saturday
  localparam logic [YEAR_W-1:0]  YEAR_RST  = 14'd1;
  localparam logic [MONTH_W-1:0] MONTH_RST = 4'd1;
  localparam logic [DAY_W-1:0]   DAY_RST   = 5'd1;
  localparam logic [WDAY_W-1:0]  WDAY_RST  = 3'd6;
  localparam logic [M400_W-1:0]  M400_RST  = 9'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LMUL,
    S_LQ,
    S_LCHK,
    S_STEP,
    S_JMUL,
    S_JACC,
    S_JFIX,
    S_WMUL,
    S_WFIX,
    S_EMIT
  } cds_state_t;

  typedef enum logic [2:0] {
    MUL_LDIV,
    MUL_LREM,
    MUL_K1,
    MUL_YDIV,
    MUL_W7
  } cds_mul_op_t;

  typedef struct packed {
    logic        in_ready;
    logic        take;
    logic        lq_cap;
    logic        lchk;
    logic        step_en;
    logic        jacc;
    logic        jfix;
    logic        wfix;
    logic        emit;
    cds_mul_op_t mul_sel;
  } cds_ctl_t;

  typedef struct packed {
    logic lok;
    logic step_done;
    logic out_free;
  } cds_sts_t;

  function automatic logic leap_of_m400(input logic [M400_W-1:0] m);
    logic cent;
    cent = (m == M400_W'(CENTURY)) || (m == M400_W'(2 * CENTURY)) ||
           (m == M400_W'(3 * CENTURY));
    return (m[1:0] == 2'b00) && !cent;
  endfunction

  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                               input logic leap);
    logic [DAY_W-1:0] n;
    case (month)
      4'd2:                         n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:      n = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:           n = 5'd31;
      default:                      n = 5'd0;
    endcase
    return n;
  endfunction

  // floor((306*mm + 5) / 10) for the March-based month index
  function automatic logic [K2_W-1:0] k2_of(input logic [MONTH_W-1:0] mm);
    logic [K2_W-1:0] k;
    case (mm)
      4'd0:    k = 9'd0;
      4'd1:    k = 9'd31;
      4'd2:    k = 9'd61;
      4'd3:    k = 9'd92;
      4'd4:    k = 9'd122;
      4'd5:    k = 9'd153;
      4'd6:    k = 9'd184;
      4'd7:    k = 9'd214;
      4'd8:    k = 9'd245;
      4'd9:    k = 9'd275;
      4'd10:   k = 9'd306;
      4'd11:   k = 9'd337;
      default: k = 9'd0;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

[rtl/core/cds_if.sv]
// Request and response channel interfaces of the calendar date stepper.
`default_nettype none

interface cds_req_if import cds_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [YEAR_W-1:0]  load_year;
  logic [MONTH_W-1:0] load_month;
  logic [DAY_W-1:0]   load_day;
  logic [CNT_W-1:0]   step_count;

  modport source (output valid, action, load_year, load_month, load_day, step_count,
                  input ready);
  modport sink   (input valid, action, load_year, load_month, load_day, step_count,
                  output ready);
endinterface

interface cds_rsp_if import cds_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  cur_year;
  logic [MONTH_W-1:0] cur_month;
  logic [DAY_W-1:0]   cur_day;
  logic [WDAY_W-1:0]  cur_weekday;
  logic [JDN_W-1:0]   julian_day;
  logic               is_leap;
  logic               range_error;

  modport source (output valid, cur_year, cur_month, cur_day, cur_weekday, julian_day,
                  is_leap, range_error, input ready);
  modport sink   (input valid, cur_year, cur_month, cur_day, cur_weekday, julian_day,
                  is_leap, range_error, output ready);
endinterface

`default_nettype wire

[rtl/core/cds_mul.sv]
// Shared unsigned multiplier with a registered product.
`default_nettype none

module cds_mul import cds_pkg::*; #(
  parameter int AW = MUL_AW,
  parameter int BW = MUL_BW
) (
  input  wire logic             clk,
  input  wire logic [AW-1:0]    a,
  input  wire logic [BW-1:0]    b,
  output logic      [AW+BW-1:0] p
);

  always_ff @(posedge clk) begin
    p <= (AW+BW)'(a) * (AW+BW)'(b);
  end

endmodule

`default_nettype wire

[rtl/core/cds_ctrl.sv]
// Sequencer for load check, day stepping, Julian day and weekday passes.
`default_nettype none

module cds_ctrl import cds_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [ACT_W-1:0] action,
  input  wire cds_sts_t         sts,
  output cds_ctl_t              ctl
);

  cds_state_t state, state_next;
  logic       take;

  assign take = in_valid && (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          case (action)
            ACT_LOAD:          state_next = S_LMUL;
            ACT_FWD, ACT_BACK: state_next = S_STEP;
            default:           state_next = S_JMUL;
          endcase
        end
      end
      S_LMUL: state_next = S_LQ;
      S_LQ:   state_next = S_LCHK;
      S_LCHK: state_next = S_JMUL;
      S_STEP: begin
        if (sts.step_done) begin
          state_next = S_JMUL;
        end
      end
      S_JMUL: state_next = S_JACC;
      S_JACC: state_next = S_JFIX;
      S_JFIX: state_next = sts.lok ? S_WMUL : S_EMIT;
      S_WMUL: state_next = S_WFIX;
      S_WFIX: state_next = S_EMIT;
      S_EMIT: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl         = '0;
    ctl.mul_sel = MUL_K1;
    ctl.take    = take;
    unique case (state)
      S_IDLE: ctl.in_ready = 1'b1;
      S_LMUL: ctl.mul_sel  = MUL_LDIV;
      S_LQ: begin
        ctl.mul_sel = MUL_LREM;
        ctl.lq_cap  = 1'b1;
      end
      S_LCHK: ctl.lchk    = 1'b1;
      S_STEP: ctl.step_en = 1'b1;
      S_JMUL: ctl.mul_sel = MUL_K1;
      S_JACC: begin
        ctl.mul_sel = MUL_YDIV;
        ctl.jacc    = 1'b1;
      end
      S_JFIX: ctl.jfix    = 1'b1;
      S_WMUL: ctl.mul_sel = MUL_W7;
      S_WFIX: ctl.wfix    = 1'b1;
      S_EMIT: ctl.emit    = sts.out_free;
      default: ctl.in_ready = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/calendar_date_stepper_jdn.sv]
// Calendar date stepper: date register, day stepping, Julian day number, weekday.
// A load runs a checking pass, a Julian day pass and, if accepted, a weekday pass; a step
//   runs the step loop (stopped early if the year range stops it), then the Julian day pass;
//   the unused action runs only the Julian day pass. The passes share the one 24x24 multiplier.
//   One request at a time; ready is high only while idle.
// Reset (synchronous, rst high): date 0001-01-01, Saturday, no response pending.
`default_nettype none

module calendar_date_stepper_jdn import cds_pkg::*; #(
  parameter int unsigned YEAR_MAX  = YEAR_MAX_DEF,
  parameter int unsigned COUNT_MAX = COUNT_MAX_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  cds_req_if.sink   req,
  cds_rsp_if.source rsp
);

  localparam logic [YEAR_W-1:0] YMAX = YEAR_W'(YEAR_MAX);
  localparam int PW = MUL_AW + MUL_BW;

  cds_ctl_t ctl;
  cds_sts_t sts;

  // Date state; ymod400 tracks year mod 400 so the leap test needs no divider
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DAY_W-1:0]   day;
  logic [WDAY_W-1:0]  weekday;
  logic [M400_W-1:0]  ymod400;
  logic [CNT_W-1:0]   days_left;

  // Latched request
  logic [ACT_W-1:0]   l_action;
  logic [YEAR_W-1:0]  l_year;
  logic [MONTH_W-1:0] l_month;
  logic [DAY_W-1:0]   l_day;
  logic [QY_W-1:0]    lq;

  logic               lok;
  logic               err;
  logic [ACC_W-1:0]   acc;

  // Response register
  logic               out_valid;

  // Shared multiplier
  logic [MUL_AW-1:0]  mul_a;
  logic [MUL_BW-1:0]  mul_b;
  logic [PW-1:0]      prod;

  // Derived values
  logic [CNT_W-1:0]   cnt_sat;
  logic               leap_cur;
  logic [YEAR_W-1:0]  yy;
  logic [MONTH_W-1:0] mm;
  logic [QY_W-1:0]    q_p;
  logic [6:0]         rem100;
  logic [M400_W-1:0]  l_mod400;
  logic               l_ok;
  logic [9:0]         greg_t;
  logic [ACC_W-1:0]   wd_x;

  // Step results
  logic [YEAR_W-1:0]  year_next;
  logic [MONTH_W-1:0] month_next;
  logic [DAY_W-1:0]   day_next;
  logic [M400_W-1:0]  ymod400_next;
  logic [WDAY_W-1:0]  weekday_next;
  logic               step_hit;

  cds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .action   (req.action),
    .sts      (sts),
    .ctl      (ctl)
  );

  cds_mul #(
    .AW (MUL_AW),
    .BW (MUL_BW)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign req.ready = ctl.in_ready;

  assign cnt_sat  = (32'(req.step_count) > COUNT_MAX) ? CNT_W'(COUNT_MAX) : req.step_count;
  assign leap_cur = leap_of_m400(ymod400);

  // JDN year/month folding: January and February count in the previous year
  assign yy = year - {{(YEAR_W-1){1'b0}}, (month < MARCH)};
  assign mm = (month >= MARCH) ? (month - MARCH) : (month + MM_SHIFT);

  // Quotient by 100 out of the product register (load year or JDN year)
  assign q_p = prod[RCP100_SH +: QY_W];

  // Load check: ly mod 400 = (q mod 4)*100 + (ly - 100*q)
  assign rem100   = 7'(l_year - prod[YEAR_W-1:0]);
  assign l_mod400 = (M400_W'(lq[1:0]) * M400_W'(CENTURY)) + M400_W'(rem100);
  assign l_ok     = (l_year != '0) && (l_year <= YMAX) &&
                    (l_month != '0) && (l_month <= MONTHS) &&
                    (l_day != '0) && (l_day <= days_in(l_month, leap_of_m400(l_mod400)));

  // Gregorian correction term floor(3*(q+49)/4)
  assign greg_t = 10'(((10'(q_p) + 10'(GREG_CENT)) * 10'd3) >> 2);

  assign wd_x = acc + ACC_W'(1);

  always_comb begin
    unique case (ctl.mul_sel)
      MUL_LDIV: begin
        mul_a = MUL_AW'(l_year);
        mul_b = MUL_BW'(RCP100);
      end
      MUL_LREM: begin
        mul_a = MUL_AW'(q_p);
        mul_b = MUL_BW'(CENTURY);
      end
      MUL_K1: begin
        mul_a = MUL_AW'(yy) + MUL_AW'(JDN_YOFS);
        mul_b = MUL_BW'(JDN_MUL);
      end
      MUL_YDIV: begin
        mul_a = MUL_AW'(yy);
        mul_b = MUL_BW'(RCP100);
      end
      MUL_W7: begin
        mul_a = MUL_AW'(wd_x);
        mul_b = MUL_BW'(RCP7);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // One day forward or back, with month and year carry or borrow
  always_comb begin
    year_next    = year;
    month_next   = month;
    day_next     = day;
    ymod400_next = ymod400;
    step_hit     = 1'b0;
    if (l_action == ACT_FWD) begin
      weekday_next = (weekday == WD_LAST) ? '0 : weekday + WDAY_W'(1);
      priority if (day < days_in(month, leap_cur)) begin
        day_next = day + DAY_W'(1);
      end else if (month < MONTHS) begin
        month_next = month + MONTH_W'(1);
        day_next   = DAY_RST;
      end else if (year < YMAX) begin
        year_next    = year + YEAR_W'(1);
        month_next   = MONTH_RST;
        day_next     = DAY_RST;
        ymod400_next = (ymod400 == M400_W'(QUAD_CENT - 1)) ? '0 : ymod400 + M400_W'(1);
      end else begin
        step_hit = 1'b1;
      end
    end else begin
      weekday_next = (weekday == '0) ? WD_LAST : weekday - WDAY_W'(1);
      priority if (day > DAY_RST) begin
        day_next = day - DAY_W'(1);
      end else if (month > MONTH_RST) begin
        month_next = month - MONTH_W'(1);
        day_next   = days_in(month - MONTH_W'(1), leap_cur);
      end else if (year > YEAR_RST) begin
        year_next    = year - YEAR_W'(1);
        month_next   = MONTHS;
        day_next     = 5'd31;
        ymod400_next = (ymod400 == '0) ? M400_W'(QUAD_CENT - 1) : ymod400 - M400_W'(1);
      end else begin
        step_hit = 1'b1;
      end
    end
  end

  assign sts.lok       = lok;
  assign sts.step_done = (days_left <= CNT_W'(1)) || step_hit;
  assign sts.out_free  = !out_valid || rsp.ready;

  // Date, counter and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      year      <= YEAR_RST;
      month     <= MONTH_RST;
      day       <= DAY_RST;
      weekday   <= WDAY_RST;
      ymod400   <= M400_RST;
      days_left <= '0;
      lok       <= 1'b0;
      err       <= 1'b0;
    end else begin
      if (ctl.take) begin
        lok       <= 1'b0;
        err       <= 1'b0;
        days_left <= ((req.action == ACT_FWD) || (req.action == ACT_BACK)) ? cnt_sat : '0;
      end
      if (ctl.lchk) begin
        if (l_ok) begin
          year    <= l_year;
          month   <= l_month;
          day     <= l_day;
          ymod400 <= l_mod400;
          lok     <= 1'b1;
        end else begin
          err <= 1'b1;
        end
      end
      if (ctl.step_en && (days_left != '0)) begin
        if (step_hit) begin
          err       <= 1'b1;
          days_left <= '0;
        end else begin
          year      <= year_next;
          month     <= month_next;
          day       <= day_next;
          ymod400   <= ymod400_next;
          weekday   <= weekday_next;
          days_left <= days_left - CNT_W'(1);
        end
      end
      // Weekday of a loaded date: (JDN+1) mod 7; the remainder is x + q mod 8
      if (ctl.wfix) begin
        weekday <= wd_x[WDAY_W-1:0] + prod[RCP7_SH +: WDAY_W];
      end
    end
  end

  // Request latch and JDN accumulator
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      l_action <= req.action;
      l_year   <= req.load_year;
      l_month  <= req.load_month;
      l_day    <= req.load_day;
    end
    if (ctl.lq_cap) begin
      lq <= q_p;
    end
    if (ctl.jacc) begin
      acc <= prod[ACC_W+1:2] + ACC_W'(k2_of(mm)) + ACC_W'(day) + ACC_W'(JDN_DOFS);
    end
    // Past the calendar switch: subtract floor(3*(q+49)/4) - 38
    if (ctl.jfix && (acc > ACC_W'(GREG_START))) begin
      acc <= acc + ACC_W'(GREG_OFS) - ACC_W'(greg_t);
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      rsp.cur_year    <= year;
      rsp.cur_month   <= month;
      rsp.cur_day     <= day;
      rsp.cur_weekday <= weekday;
      rsp.julian_day  <= acc[JDN_W-1:0];
      rsp.is_leap     <= leap_cur;
      rsp.range_error <= err;
    end
  end

  assign rsp.valid = out_valid;

endmodule

`default_nettype wire
